FILE: sv/hvt_pkg.sv
// Shared types and constants for the homogeneous vertex transform.
package hvt_pkg;

	localparam int DATA_WIDTH = 32;              // saturation width of a result
	localparam int COMP_W     = 32;              // width of a component word
	localparam int FRAC_W     = 16;              // Q16.16
	localparam int NUM_ROWS   = 4;
	localparam int NUM_COLS   = 4;
	localparam int NUM_PAIRS  = 8;
	localparam int PAIR_W     = 2 * COMP_W;
	localparam int IDX_W      = $clog2(NUM_PAIRS);
	localparam int PROD_W     = 2 * COMP_W;
	localparam int SUM_W      = PROD_W + 2;      // four products, no wrap
	localparam int SHIFT_W    = SUM_W - FRAC_W;

	typedef logic signed [COMP_W-1:0] comp_t;

	localparam comp_t ONE_Q16 = comp_t'(1) <<< FRAC_W;
	localparam comp_t SAT_HI  = comp_t'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam comp_t SAT_LO  = ~SAT_HI;

	// identity matrix: 1.0 on coefficients 0, 5, 10 and 15
	localparam logic [NUM_PAIRS-1:0][PAIR_W-1:0] PAIR_RESET = {
		64'h0001_0000_0000_0000,   // pair 7
		64'h0000_0000_0000_0000,   // pair 6
		64'h0000_0000_0001_0000,   // pair 5
		64'h0000_0000_0000_0000,   // pair 4
		64'h0000_0000_0000_0000,   // pair 3
		64'h0001_0000_0000_0000,   // pair 2
		64'h0000_0000_0000_0000,   // pair 1
		64'h0000_0000_0001_0000    // pair 0
	};

	typedef enum logic {
		ACT_AFFINE = 1'b0,
		ACT_FULL   = 1'b1
	} action_t;

	// load enables of the lane pipeline stages
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

endpackage

FILE: sv/hvt_lane.sv
// One row lane: four products, adder tree, floor shift and saturation.
module hvt_lane (
	input  logic              clk,
	input  hvt_pkg::stage_en_t ctl,
	input  hvt_pkg::comp_t    coef [hvt_pkg::NUM_COLS],
	input  hvt_pkg::comp_t    vec  [hvt_pkg::NUM_COLS],
	output hvt_pkg::comp_t    res_s3,
	output logic              ovf_s3
);

	logic signed [hvt_pkg::PROD_W-1:0]  prod_s1 [hvt_pkg::NUM_COLS];
	logic signed [hvt_pkg::PROD_W:0]    sum_lo_s2;
	logic signed [hvt_pkg::PROD_W:0]    sum_hi_s2;
	logic signed [hvt_pkg::SUM_W-1:0]   total;
	logic signed [hvt_pkg::SHIFT_W-1:0] shifted;
	logic signed [hvt_pkg::SHIFT_W-1:0] sat_hi_x;
	logic signed [hvt_pkg::SHIFT_W-1:0] sat_lo_x;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
				prod_s1[c] <= hvt_pkg::PROD_W'(coef[c]) * hvt_pkg::PROD_W'(vec[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			sum_lo_s2 <= (hvt_pkg::PROD_W+1)'(prod_s1[0]) + (hvt_pkg::PROD_W+1)'(prod_s1[1]);
			sum_hi_s2 <= (hvt_pkg::PROD_W+1)'(prod_s1[2]) + (hvt_pkg::PROD_W+1)'(prod_s1[3]);
		end
	end

	// arithmetic drop of the fraction is a floor
	always_comb begin
		total    = hvt_pkg::SUM_W'(sum_lo_s2) + hvt_pkg::SUM_W'(sum_hi_s2);
		shifted  = total[hvt_pkg::SUM_W-1:hvt_pkg::FRAC_W];
		sat_hi_x = hvt_pkg::SHIFT_W'(hvt_pkg::SAT_HI);
		sat_lo_x = hvt_pkg::SHIFT_W'(hvt_pkg::SAT_LO);
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			if (shifted > sat_hi_x) begin
				res_s3 <= hvt_pkg::SAT_HI;
				ovf_s3 <= 1'b1;
			end else if (shifted < sat_lo_x) begin
				res_s3 <= hvt_pkg::SAT_LO;
				ovf_s3 <= 1'b1;
			end else begin
				// in range, so the low word is already sign-extended
				res_s3 <= shifted[hvt_pkg::COMP_W-1:0];
				ovf_s3 <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/hvt_merge.sv
// Output stage: merges the four lane results into one result word.
module hvt_merge (
	input  logic           clk,
	input  logic           en,
	input  logic           action_s3,
	input  hvt_pkg::comp_t res_s3 [hvt_pkg::NUM_ROWS],
	input  logic           ovf_s3 [hvt_pkg::NUM_ROWS],
	output hvt_pkg::comp_t out_x,
	output hvt_pkg::comp_t out_y,
	output hvt_pkg::comp_t out_z,
	output hvt_pkg::comp_t out_w,
	output logic           overflow
);

	logic full;

	assign full = (action_s3 == hvt_pkg::ACT_FULL);

	always_ff @(posedge clk) begin
		if (en) begin
			out_x    <= res_s3[0];
			out_y    <= res_s3[1];
			out_z    <= res_s3[2];
			out_w    <= full ? res_s3[3] : '0;
			overflow <= ovf_s3[0] | ovf_s3[1] | ovf_s3[2] | (full & ovf_s3[3]);
		end
	end

endmodule

FILE: sv/homogeneous_vertex_transform.sv
// Top level of the homogeneous vertex transform: matrix store, lanes and flow control.
//
// Multiplies each input vector by a column-major 4x4 matrix of signed Q16.16
// coefficients held in eight 64-bit registers (coefficient k in register k/2,
// even k in the low half; reset gives the identity). action 0 is affine mode:
// in_w is ignored and taken as 1.0, out_w reads zero and overflow covers x, y
// and z only; action 1 computes all four rows. Each result is the exact Q32.32
// dot product floored to Q16.16 and saturated, with overflow set on a clamp.
// Throughput is one word per cycle unless a stalled output backs up the stages.
// There are four register stages: the multiply stage, two adder stages (the
// second also saturates) and the output register; a word's valid moves through
// v1_s1, v2_s2 and v3_s3 before out_valid rises. Four row lanes run side by side
// and the output stage merges them. Each stage moves up when the one after it
// is empty or moving, so bubbles collapse and input words are still taken while
// a result waits at a stalled output. Matrix writes take effect at once
// (cfg_ready is always high) and must only be made while the pipeline is empty.
module homogeneous_vertex_transform (
	input  logic                       clk,
	input  logic                       arst_n,
	// matrix write port
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hvt_pkg::IDX_W-1:0]  cfg_index,
	input  logic [hvt_pkg::PAIR_W-1:0] cfg_data,
	// input words
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  hvt_pkg::comp_t             in_x,
	input  hvt_pkg::comp_t             in_y,
	input  hvt_pkg::comp_t             in_z,
	input  hvt_pkg::comp_t             in_w,
	// result words
	output logic                       out_valid,
	input  logic                       out_stall,
	output hvt_pkg::comp_t             out_x,
	output hvt_pkg::comp_t             out_y,
	output hvt_pkg::comp_t             out_z,
	output hvt_pkg::comp_t             out_w,
	output logic                       overflow
);

	logic [hvt_pkg::NUM_PAIRS-1:0][hvt_pkg::PAIR_W-1:0] pair_q;

	logic v1_s1, v2_s2, v3_s3;
	logic adv1, adv2, adv3, adv4;
	logic act_s1, act_s2, act_s3;
	hvt_pkg::stage_en_t ctl;

	hvt_pkg::comp_t vec  [hvt_pkg::NUM_COLS];
	hvt_pkg::comp_t coef [hvt_pkg::NUM_ROWS][hvt_pkg::NUM_COLS];
	hvt_pkg::comp_t res_s3 [hvt_pkg::NUM_ROWS];
	logic           ovf_s3 [hvt_pkg::NUM_ROWS];

	// ---- matrix registers ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= hvt_pkg::PAIR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pair_q[cfg_index] <= cfg_data;
		end
	end

	// coefficient k = c*4 + r sits in pair k/2, high half when k is odd
	always_comb begin
		for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
			for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
				coef[r][c] = pair_q[(c * hvt_pkg::NUM_ROWS + r) / 2]
				                   [((c * hvt_pkg::NUM_ROWS + r) % 2) * hvt_pkg::COMP_W +:
				                    hvt_pkg::COMP_W];
			end
		end
	end

	// ---- flow control: a stage loads when the next is free or moving ----
	assign adv4 = !out_valid || !out_stall;
	assign adv3 = !v3_s3 || adv4;
	assign adv2 = !v2_s2 || adv3;
	assign adv1 = !v1_s1 || adv2;
	assign in_stall = !adv1;

	assign ctl.en_s1 = adv1;
	assign ctl.en_s2 = adv2;
	assign ctl.en_s3 = adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv1) v1_s1     <= in_valid;
			if (adv2) v2_s2     <= v1_s1;
			if (adv3) v3_s3     <= v2_s2;
			if (adv4) out_valid <= v3_s3;
		end
	end

	// mode travels alongside the lane data
	always_ff @(posedge clk) begin
		if (adv1) act_s1 <= action;
		if (adv2) act_s2 <= act_s1;
		if (adv3) act_s3 <= act_s2;
	end

	// affine mode puts 1.0 in place of w
	assign vec[0] = in_x;
	assign vec[1] = in_y;
	assign vec[2] = in_z;
	assign vec[3] = (action == hvt_pkg::ACT_FULL) ? in_w : hvt_pkg::ONE_Q16;

	// ---- row lanes ----
	for (genvar r = 0; r < hvt_pkg::NUM_ROWS; r++) begin : g_lane
		hvt_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.coef   (coef[r]),
			.vec    (vec),
			.res_s3 (res_s3[r]),
			.ovf_s3 (ovf_s3[r])
		);
	end

	// ---- merge into the output register ----
	hvt_merge u_merge (
		.clk       (clk),
		.en        (adv4),
		.action_s3 (act_s3),
		.res_s3    (res_s3),
		.ovf_s3    (ovf_s3),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.overflow  (overflow)
	);

	// ---- assertions ----
	// input is held off only when the whole pipe is backed up
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v1_s1 && v2_s2 && v3_s3 && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	// a held stage keeps its word
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && !adv3) |=> v3_s3)
		else $error("stage 3 dropped a word while held");

	// overflow means some component sits at a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |->
			(out_x == hvt_pkg::SAT_HI || out_x == hvt_pkg::SAT_LO ||
			 out_y == hvt_pkg::SAT_HI || out_y == hvt_pkg::SAT_LO ||
			 out_z == hvt_pkg::SAT_HI || out_z == hvt_pkg::SAT_LO ||
			 out_w == hvt_pkg::SAT_HI || out_w == hvt_pkg::SAT_LO))
		else $error("overflow flagged with no saturated component");

endmodule
